>>> hw/rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants of the position and profit tracker
// Field widths, operation and state codes, and controller command/status.
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

  localparam int PRICE_W  = 24;
  localparam int QTY_W    = 20;
  localparam int FRAC_W   = 16;
  localparam int POS_W    = 32;
  localparam int PROFIT_W = 64;
  localparam int AVG_W    = PRICE_W + FRAC_W;
  localparam int HALF_W   = AVG_W / 2;
  localparam int MUL_B_W  = POS_W;
  localparam int PROD_W   = HALF_W + MUL_B_W;
  localparam int ACC_W    = AVG_W + MUL_B_W;
  localparam int DVS_W    = MUL_B_W + 1;
  localparam int DIV_STEPS = AVG_W;
  localparam int DCNT_W   = $clog2(DIV_STEPS);
  localparam int STEP_W   = 2;

  localparam logic [STEP_W-1:0] STEP_LAST_AVG  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_LAST_DIFF = STEP_W'(1);
  localparam logic [DCNT_W-1:0] DIV_LAST       = DCNT_W'(DIV_STEPS - 1);

  localparam logic REQ_FILL  = 1'b0;
  localparam logic REQ_MARK  = 1'b1;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic [POS_W-1:0]    POS_MAX    = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0]    POS_MIN    = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [PROFIT_W-1:0] PROFIT_MAX = {1'b0, {(PROFIT_W-1){1'b1}}};
  localparam logic [PROFIT_W-1:0] PROFIT_MIN = {1'b1, {(PROFIT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_NONE,
    OP_AVG,
    OP_REAL,
    OP_MARK
  } ppt_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_MUL_P,
    S_MUL_A,
    S_DIV_INIT,
    S_DIV,
    S_FIN
  } ppt_state_e;

  typedef struct packed {
    logic              capture;
    logic              acc_clr;
    logic              mul_go;
    logic              acc_add;
    logic [STEP_W-1:0] step;
    logic              div_load;
    logic              div_step;
    logic              commit;
  } ppt_cmd_t;

  typedef struct packed {
    ppt_op_e op;
    logic    out_free;
  } ppt_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/ppt_if.sv
// ----------------------------------------------------------------------------
// ppt_if: request and result channels of the position and profit tracker
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppt_req_if import ppt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic               side;
  logic [PRICE_W-1:0] price;
  logic [QTY_W-1:0]   quantity;

  modport source (output valid, req_type, side, price, quantity, input ready);
  modport sink   (input valid, req_type, side, price, quantity, output ready);
endinterface

interface ppt_res_if import ppt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [POS_W-1:0]    position;
  logic        [AVG_W-1:0]    entry_price;
  logic signed [PROFIT_W-1:0] booked_profit;
  logic signed [PROFIT_W-1:0] open_profit;

  modport source (output valid, position, entry_price, booked_profit, open_profit,
                  input ready);
  modport sink   (input valid, position, entry_price, booked_profit, open_profit,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ppt_ctrl.sv
// ----------------------------------------------------------------------------
// ppt_ctrl: sequencer of the position and profit tracker
// Steps the multiply-accumulate, the radix-2 divider and the state commit.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_ctrl import ppt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  input  wire ppt_sts_t sts_i,
  output ppt_cmd_t      cmd_o
);

  ppt_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [STEP_W-1:0] step_last;

  assign step_last = (sts_i.op == OP_AVG) ? STEP_LAST_AVG : STEP_LAST_DIFF;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (req_valid_i) state_d = S_START;
      S_START:    state_d = (sts_i.op == OP_NONE) ? S_FIN : S_MUL_P;
      S_MUL_P:    state_d = S_MUL_A;
      S_MUL_A: begin
        if (step_q == step_last) begin
          state_d = (sts_i.op == OP_AVG) ? S_DIV_INIT : S_FIN;
        end else begin
          state_d = S_MUL_P;
        end
      end
      S_DIV_INIT: state_d = S_DIV;
      S_DIV:      if (cnt_q == DIV_LAST) state_d = S_FIN;
      S_FIN:      if (sts_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    step_d = step_q;
    cnt_d  = cnt_q;
    if (state_q == S_START) step_d = '0;
    if (state_q == S_MUL_A) step_d = step_q + 1'b1;
    if (state_q == S_DIV_INIT) cnt_d = '0;
    if (state_q == S_DIV) cnt_d = cnt_q + 1'b1;
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.step  = step_q;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      S_START:    cmd_o.acc_clr  = 1'b1;
      S_MUL_P:    cmd_o.mul_go   = 1'b1;
      S_MUL_A:    cmd_o.acc_add  = 1'b1;
      S_DIV_INIT: cmd_o.div_load = 1'b1;
      S_DIV:      cmd_o.div_step = 1'b1;
      S_FIN:      cmd_o.commit   = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_step_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_A && sts_i.op != OP_AVG) |-> (step_q <= STEP_LAST_DIFF))
    else $error("product step beyond the difference product");

  a_div_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_DIV_INIT) |-> (sts_i.op == OP_AVG))
    else $error("divider running for an item that does not average");

  a_op_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_START) |-> $stable(sts_i.op))
    else $error("operation changed while an item is in progress");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/ppt_dp.sv
// ----------------------------------------------------------------------------
// ppt_dp: datapath of the position and profit tracker
// Decode, 20x32 multiply-accumulate, radix-2 divider, saturation, state.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_dp import ppt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ppt_req_if.sink       req,
  ppt_res_if.source     res,
  input  wire ppt_cmd_t cmd_i,
  output ppt_sts_t      sts_o
);

  // architectural state
  logic [POS_W-1:0]    net_pos_q;
  logic [AVG_W-1:0]    avg_q;
  logic [PROFIT_W-1:0] booked_q;
  logic [PROFIT_W-1:0] open_q;
  logic                out_valid_q;

  // captured item
  ppt_op_e             op_q, op_d;
  logic                sell_q, cross_q, cross_d, dneg_q, dneg_d;
  logic [AVG_W-1:0]    mag_q, mag_d, px_q;
  logic [MUL_B_W-1:0]  nmul_q, nmul_d, absq_q;
  logic [QTY_W-1:0]    qty_q;

  // decode
  logic                pos_neg, pos_pos;
  logic [MUL_B_W-1:0]  abs_pos, qty_ext;
  logic [AVG_W-1:0]    px_in, dif_a, dif_b;

  always_comb begin
    pos_neg = net_pos_q[POS_W-1];
    pos_pos = !pos_neg && (net_pos_q != '0);
    abs_pos = pos_neg ? (~net_pos_q + 1'b1) : net_pos_q;
    px_in   = {req.price, {FRAC_W{1'b0}}};
    qty_ext = {{(MUL_B_W-QTY_W){1'b0}}, req.quantity};
    op_d    = OP_NONE;
    dif_a   = avg_q;
    dif_b   = px_in;
    nmul_d  = abs_pos;
    cross_d = qty_ext > abs_pos;
    if (req.req_type == REQ_MARK) begin
      op_d = OP_MARK;
      if (pos_pos) begin
        dif_a = px_in;
        dif_b = avg_q;
      end
    end else if (req.quantity != '0) begin
      if (req.side == SIDE_BUY) begin
        op_d = pos_neg ? OP_REAL : OP_AVG;
      end else if (pos_pos) begin
        op_d  = OP_REAL;
        dif_a = px_in;
        dif_b = avg_q;
      end else begin
        op_d = OP_AVG;
      end
      if (op_d == OP_REAL && !cross_d) nmul_d = qty_ext;
    end
    dneg_d = dif_a < dif_b;
    mag_d  = dneg_d ? (dif_b - dif_a) : (dif_a - dif_b);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sell_q  <= req.side;
      cross_q <= cross_d;
      dneg_q  <= dneg_d;
      mag_q   <= mag_d;
      nmul_q  <= nmul_d;
      absq_q  <= abs_pos;
      px_q    <= px_in;
      qty_q   <= req.quantity;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NONE;
    end else if (cmd_i.capture) begin
      op_q <= op_d;
    end
  end

  // multiply-accumulate over 20-bit halves
  logic [AVG_W-1:0]   mul_src;
  logic [HALF_W-1:0]  mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_q;
  logic               prod_hi_q;
  logic [ACC_W-1:0]   acc_q;

  always_comb begin
    if (op_q == OP_AVG) begin
      mul_src = cmd_i.step[1] ? px_q : avg_q;
      mul_b   = cmd_i.step[1] ? {{(MUL_B_W-QTY_W){1'b0}}, qty_q} : absq_q;
    end else begin
      mul_src = mag_q;
      mul_b   = nmul_q;
    end
    mul_a = cmd_i.step[0] ? mul_src[AVG_W-1:HALF_W] : mul_src[HALF_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      prod_q    <= {{(PROD_W-HALF_W){1'b0}}, mul_a} * {{(PROD_W-MUL_B_W){1'b0}}, mul_b};
      prod_hi_q <= cmd_i.step[0];
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + (prod_hi_q ? {prod_q, {HALF_W{1'b0}}} : {{HALF_W{1'b0}}, prod_q});
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [AVG_W-1:0] quo_q;
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic             rem_ge;

  assign rem_sh  = {rem_q, quo_q[AVG_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign rem_ge  = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= {1'b0, acc_q[ACC_W-1:AVG_W]};
      quo_q <= acc_q[AVG_W-1:0];
      dvs_q <= {1'b0, absq_q} + {{(DVS_W-QTY_W){1'b0}}, qty_q};
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_q <= {quo_q[AVG_W-2:0], rem_ge};
    end
  end

  // saturation and commit
  logic                term_ovf;
  logic [PROFIT_W-1:0] term;
  logic [PROFIT_W:0]   bsum;
  logic [PROFIT_W-1:0] booked_d;
  logic [POS_W+1:0]    pos_ext, qty_w, psum;
  logic [POS_W-1:0]    pos_d;

  always_comb begin
    term_ovf = |acc_q[ACC_W-1:PROFIT_W-1];
    if (!dneg_q) begin
      term = term_ovf ? PROFIT_MAX : acc_q[PROFIT_W-1:0];
    end else begin
      term = term_ovf ? PROFIT_MIN : (~acc_q[PROFIT_W-1:0] + 1'b1);
    end
    bsum = {booked_q[PROFIT_W-1], booked_q} + {term[PROFIT_W-1], term};
    if (bsum[PROFIT_W] != bsum[PROFIT_W-1]) begin
      booked_d = bsum[PROFIT_W] ? PROFIT_MIN : PROFIT_MAX;
    end else begin
      booked_d = bsum[PROFIT_W-1:0];
    end
    pos_ext = {{2{net_pos_q[POS_W-1]}}, net_pos_q};
    qty_w   = {{(POS_W+2-QTY_W){1'b0}}, qty_q};
    psum    = sell_q ? (pos_ext - qty_w) : (pos_ext + qty_w);
    if (psum[POS_W+1:POS_W-1] == 3'b000 || psum[POS_W+1:POS_W-1] == 3'b111) begin
      pos_d = psum[POS_W-1:0];
    end else begin
      pos_d = psum[POS_W+1] ? POS_MIN : POS_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_pos_q   <= '0;
      avg_q       <= '0;
      booked_q    <= '0;
      open_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        case (op_q)
          OP_AVG: begin
            avg_q     <= quo_q;
            net_pos_q <= pos_d;
          end
          OP_REAL: begin
            booked_q  <= booked_d;
            net_pos_q <= pos_d;
            if (cross_q) avg_q <= px_q;
          end
          OP_MARK: open_q <= term;
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res.valid         = out_valid_q;
  assign res.position      = net_pos_q;
  assign res.entry_price   = avg_q;
  assign res.booked_profit = booked_q;
  assign res.open_profit   = open_q;

  assign sts_o.op       = op_q;
  assign sts_o.out_free = !out_valid_q || res.ready;

`ifndef NO_ASSERTIONS
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || res.ready))
    else $error("result overwritten before transfer");

  a_valid_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res.ready && !cmd_i.commit) |=> !out_valid_q)
    else $error("result repeated after transfer");

  a_mark_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && op_q == OP_MARK) |=> ($stable(net_pos_q) && $stable(booked_q)))
    else $error("mark changed position or booked profit");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/position_pnl_tracker_top.sv
// ----------------------------------------------------------------------------
// position_pnl_tracker_top: average-cost position and profit tracker
// Net position, average entry, realized and unrealized profit per item.
// ----------------------------------------------------------------------------
// One item is in work at a time and every item returns one result with the
// figures after it. A request is taken when the block is idle. A fill of zero
// quantity goes straight to the result; a mark or a reducing fill first forms
// two 20x32 partial products, and a fill that opens or adds to the position
// forms the partial products of its weighted average, which then goes through
// a restoring divider that yields one of 40 quotient bits per cycle. The next
// request is taken in the cycle after the result is loaded. The result
// register stands apart from the request side: a new request is taken while
// the last result waits.
`default_nettype none

module position_pnl_tracker_top import ppt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ppt_req_if.sink   req_i,
  ppt_res_if.source res_o
);

  ppt_cmd_t cmd;
  ppt_sts_t sts;

  ppt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppt_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_i),
    .res    (res_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_position_pnl_tracker_top.sv
// ----------------------------------------------------------------------------
// tb_position_pnl_tracker_top: self-checking bench of the position tracker
// Drives fills and marks over the request channel, predicts the position,
// average entry and profit figures in the bench, and checks each result
// transfer field by field. The run covers a short stimulus table, random
// phases, most with sender or receiver idling, and a closing run that swings
// both profit figures into saturation in each direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_position_pnl_tracker_top;
  import ppt_pkg::*;

  typedef struct packed {
    logic               req_type;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
  } order_t;

  typedef struct packed {
    logic signed [POS_W-1:0]    position;
    logic        [AVG_W-1:0]    entry_price;
    logic signed [PROFIT_W-1:0] booked_pnl;
    logic signed [PROFIT_W-1:0] open_pnl;
  } figures_t;

  typedef struct packed {
    order_t   ord;
    logic     pinned;
    figures_t want;
  } step_row_t;

  localparam logic [PRICE_W-1:0] PX_TOP  = '1;
  localparam logic [QTY_W-1:0]   QTY_TOP = '1;
  localparam logic [AVG_W-1:0]   AVG_TOP = {PX_TOP, {FRAC_W{1'b0}}};

  logic clk;
  logic rst_n;

  ppt_req_if req ();
  ppt_res_if res ();

  position_pnl_tracker_top uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .res_o (res)
  );

  logic [POS_W-1:0]    book_pos;
  logic [AVG_W-1:0]    book_avg;
  logic [PROFIT_W-1:0] book_real;
  logic [PROFIT_W-1:0] book_unreal;

  figures_t            owed_q[$];
  figures_t            owed_now;
  figures_t            predicted;
  step_row_t           steps[$];
  logic                offer_pinned;
  figures_t            offer_want;
  int                  send_idle;
  int                  stall_pct;
  int                  err_count;
  logic [PRICE_W-1:0]  anchor_px;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic order_t mk_order(logic rt, logic sd, logic [PRICE_W-1:0] px,
                                      logic [QTY_W-1:0] qty);
    order_t o;
    o.req_type = rt;
    o.side     = sd;
    o.price    = px;
    o.quantity = qty;
    return o;
  endfunction

  function automatic figures_t figs(logic [POS_W-1:0] p, logic [AVG_W-1:0] e,
                                    logic [PROFIT_W-1:0] b, logic [PROFIT_W-1:0] u);
    figures_t f;
    f.position    = p;
    f.entry_price = e;
    f.booked_pnl  = b;
    f.open_pnl    = u;
    return f;
  endfunction

  // (a - b) * n, clamped to the signed profit range
  function automatic logic [PROFIT_W-1:0] scaled_gap(logic [AVG_W-1:0] a,
                                                     logic [AVG_W-1:0] b,
                                                     logic [63:0] n);
    logic [127:0] mag;
    if (a >= b) begin
      mag = 128'(a - b) * 128'(n);
      if (mag > 128'(PROFIT_MAX)) return PROFIT_MAX;
      return mag[PROFIT_W-1:0];
    end
    mag = 128'(b - a) * 128'(n);
    if (mag >= 128'(PROFIT_MIN)) return PROFIT_MIN;
    return -mag[PROFIT_W-1:0];
  endfunction

  function automatic logic [PROFIT_W-1:0] add_clamped(logic [PROFIT_W-1:0] a,
                                                      logic [PROFIT_W-1:0] b);
    logic [PROFIT_W:0] s;
    s = {a[PROFIT_W-1], a} + {b[PROFIT_W-1], b};
    if (s[PROFIT_W] != s[PROFIT_W-1]) return s[PROFIT_W] ? PROFIT_MIN : PROFIT_MAX;
    return s[PROFIT_W-1:0];
  endfunction

  function automatic logic [AVG_W-1:0] blend_avg(logic [AVG_W-1:0] avg, logic [63:0] old_qty,
                                                 logic [AVG_W-1:0] px, logic [63:0] q);
    logic [127:0] num;
    logic [127:0] den;
    num = 128'(avg) * 128'(old_qty) + 128'(px) * 128'(q);
    den = 128'(old_qty) + 128'(q);
    return AVG_W'(num / den);
  endfunction

  function automatic figures_t apply_order(order_t o);
    logic [63:0]      pos64;
    logic [63:0]      mag;
    logic [63:0]      q;
    logic [63:0]      nxt;
    logic [63:0]      lim_hi;
    logic [63:0]      lim_lo;
    logic [AVG_W-1:0] px;
    pos64  = {{(64-POS_W){book_pos[POS_W-1]}}, book_pos};
    mag    = pos64[63] ? -pos64 : pos64;
    px     = {o.price, {FRAC_W{1'b0}}};
    q      = 64'(o.quantity);
    lim_hi = {{(64-POS_W){1'b0}}, POS_MAX};
    lim_lo = {{(64-POS_W){1'b1}}, POS_MIN};
    if (o.req_type == REQ_FILL && q != 0) begin
      if (o.side == SIDE_BUY) begin
        if (!pos64[63]) begin
          book_avg = blend_avg(book_avg, mag, px, q);
        end else if (q > mag) begin
          book_real = add_clamped(book_real, scaled_gap(book_avg, px, mag));
          book_avg  = px;
        end else begin
          book_real = add_clamped(book_real, scaled_gap(book_avg, px, q));
        end
        nxt = pos64 + q;
      end else begin
        if (pos64[63] || pos64 == 0) begin
          book_avg = blend_avg(book_avg, mag, px, q);
        end else if (q > mag) begin
          book_real = add_clamped(book_real, scaled_gap(px, book_avg, mag));
          book_avg  = px;
        end else begin
          book_real = add_clamped(book_real, scaled_gap(px, book_avg, q));
        end
        nxt = pos64 - q;
      end
      if ($signed(nxt) > $signed(lim_hi)) book_pos = POS_MAX;
      else if ($signed(nxt) < $signed(lim_lo)) book_pos = POS_MIN;
      else book_pos = nxt[POS_W-1:0];
    end else if (o.req_type == REQ_MARK) begin
      if (!pos64[63] && pos64 != 0) book_unreal = scaled_gap(px, book_avg, mag);
      else book_unreal = scaled_gap(book_avg, px, mag);
    end
    return figs(book_pos, book_avg, book_real, book_unreal);
  endfunction

  function automatic order_t pick_order();
    order_t o;
    o.req_type = ($urandom_range(99) < 18) ? REQ_MARK : REQ_FILL;
    o.side     = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       o.price = '0;
      1:       o.price = PX_TOP;
      2, 3:    o.price = PRICE_W'($urandom);
      default: o.price = anchor_px + PRICE_W'($urandom_range(255)) - 24'd128;
    endcase
    case ($urandom_range(19))
      0:                 o.quantity = '0;
      1, 2:              o.quantity = QTY_TOP;
      3, 4, 5:           o.quantity = QTY_W'($urandom);
      6, 7, 8, 9, 10:    o.quantity = QTY_W'($urandom_range(4095));
      default:           o.quantity = QTY_W'($urandom_range(64, 1));
    endcase
    return o;
  endfunction

  task automatic add_step(order_t o, logic pinned, figures_t w);
    steps.push_back('{o, pinned, w});
  endtask

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    if (err_count <= 40) begin
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    end
  endtask

  // hold the item until its transfer
  task automatic offer(order_t o, logic pinned, figures_t w);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.req_type <= o.req_type;
    req.side     <= o.side;
    req.price    <= o.price;
    req.quantity <= o.quantity;
    offer_pinned <= pinned;
    offer_want   <= w;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    res.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && req.valid && req.ready) begin
      predicted = apply_order(mk_order(req.req_type, req.side, req.price, req.quantity));
      owed_q.push_back(offer_pinned ? offer_want : predicted);
    end
    if (rst_n && res.valid && res.ready) begin
      if (owed_q.size() == 0) begin
        flag_mismatch("result without request", 64'(res.position), '0);
      end else begin
        owed_now = owed_q.pop_front();
        if (res.position !== owed_now.position)
          flag_mismatch("position", 64'(res.position), 64'(owed_now.position));
        if (res.entry_price !== owed_now.entry_price)
          flag_mismatch("entry_price", 64'(res.entry_price), 64'(owed_now.entry_price));
        if (res.booked_profit !== owed_now.booked_pnl)
          flag_mismatch("booked_profit", res.booked_profit, owed_now.booked_pnl);
        if (res.open_profit !== owed_now.open_pnl)
          flag_mismatch("open_profit", res.open_profit, owed_now.open_pnl);
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    req.valid    <= 1'b0;
    req.req_type <= REQ_FILL;
    req.side     <= SIDE_BUY;
    req.price    <= '0;
    req.quantity <= '0;
    offer_pinned <= 1'b0;
    offer_want   <= '0;
    book_pos     = '0;
    book_avg     = '0;
    book_real    = '0;
    book_unreal  = '0;
    err_count    = 0;
    send_idle    = 0;
    stall_pct    = 0;
    anchor_px    = 24'd1000;

    add_step(mk_order(REQ_MARK, SIDE_BUY, '0, '0), 1'b1, figs('0, '0, '0, '0));
    add_step(mk_order(REQ_FILL, SIDE_BUY, PX_TOP, '0), 1'b1, figs('0, '0, '0, '0));
    add_step(mk_order(REQ_FILL, SIDE_SELL, PX_TOP, '0), 1'b1, figs('0, '0, '0, '0));
    add_step(mk_order(REQ_FILL, SIDE_BUY, PX_TOP, 20'd1), 1'b1,
             figs(32'd1, AVG_TOP, '0, '0));
    add_step(mk_order(REQ_MARK, SIDE_BUY, '0, '0), 1'b1,
             figs(32'd1, AVG_TOP, '0, -(64'(AVG_TOP))));
    add_step(mk_order(REQ_FILL, SIDE_SELL, PX_TOP, 20'd1), 1'b1,
             figs('0, AVG_TOP, '0, -(64'(AVG_TOP))));
    add_step(mk_order(REQ_MARK, SIDE_BUY, 24'd5, '0), 1'b1, figs('0, AVG_TOP, '0, '0));
    add_step(mk_order(REQ_FILL, SIDE_BUY, 24'd100, QTY_TOP), 1'b0, '0);
    add_step(mk_order(REQ_FILL, SIDE_BUY, 24'd200, QTY_TOP), 1'b0, '0);
    add_step(mk_order(REQ_FILL, SIDE_BUY, PX_TOP, 20'd3), 1'b0, '0);
    add_step(mk_order(REQ_FILL, SIDE_SELL, 24'd300, 20'd1000), 1'b0, '0);
    add_step(mk_order(REQ_MARK, SIDE_SELL, '0, QTY_TOP), 1'b0, '0);
    add_step(mk_order(REQ_FILL, SIDE_SELL, '0, QTY_TOP), 1'b0, '0);
    add_step(mk_order(REQ_FILL, SIDE_SELL, PX_TOP, 20'd1048574), 1'b0, '0);
    add_step(mk_order(REQ_FILL, SIDE_SELL, 24'd50, QTY_TOP), 1'b0, '0);
    add_step(mk_order(REQ_MARK, SIDE_BUY, PX_TOP, '0), 1'b0, '0);
    add_step(mk_order(REQ_FILL, SIDE_SELL, '0, 20'd1), 1'b0, '0);
    add_step(mk_order(REQ_MARK, SIDE_SELL, 24'd77, 20'd9), 1'b0, '0);
    add_step(mk_order(REQ_FILL, SIDE_BUY, 24'd40, 20'd1048571), 1'b0, '0);
    add_step(mk_order(REQ_MARK, SIDE_BUY, 24'd123, '0), 1'b0, '0);
    add_step(mk_order(REQ_MARK, SIDE_SELL, PX_TOP, QTY_TOP), 1'b0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) offer(steps[i].ord, steps[i].pinned, steps[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle = 0;  stall_pct = 0;  end
        1:       begin send_idle = 54; stall_pct = 0;  end
        2:       begin send_idle = 0;  stall_pct = 54; end
        default: begin send_idle = 33; stall_pct = 33; end
      endcase
      anchor_px = PRICE_W'($urandom);
      repeat (450) offer(pick_order(), 1'b0, '0);
    end

    // swing both profit figures into saturation, up and then down
    send_idle = 33;
    stall_pct = 33;
    repeat (12) offer(mk_order(REQ_FILL, SIDE_BUY, '0, QTY_TOP), 1'b0, '0);
    offer(mk_order(REQ_MARK, SIDE_BUY, PX_TOP, '0), 1'b0, '0);
    repeat (24) offer(mk_order(REQ_FILL, SIDE_SELL, PX_TOP, QTY_TOP), 1'b0, '0);
    offer(mk_order(REQ_MARK, SIDE_SELL, '0, '0), 1'b0, '0);
    repeat (36) offer(mk_order(REQ_FILL, SIDE_BUY, PX_TOP, QTY_TOP), 1'b0, '0);
    offer(mk_order(REQ_MARK, SIDE_BUY, '0, '0), 1'b0, '0);
    repeat (48) offer(mk_order(REQ_FILL, SIDE_SELL, '0, QTY_TOP), 1'b0, '0);
    offer(mk_order(REQ_MARK, SIDE_SELL, PX_TOP, QTY_TOP), 1'b0, '0);

    req.valid <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_if.sv
hw/rtl/ppt_ctrl.sv
hw/rtl/ppt_dp.sv
hw/rtl/position_pnl_tracker_top.sv
tb/sv/tb_position_pnl_tracker_top.sv
